// File: design/bm3_pkg.sv
// Shared types, constants and helpers for the 3x3 binary morphology block.
// Used by the result channel interface, the register block and the core.
// Depends on nothing.
package bm3_pkg;

    // Image size limits and the coordinate widths that follow from them.
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Register field widths, fixed by the programming model.
    localparam int FWIDTH_W  = 9;
    localparam int FHEIGHT_W = 11;

    // APB port geometry.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // One line store entry holds the pixel of row r-1 (bit 0) and r-2 (bit 1).
    localparam int LINE_W = 2;

    // Configuration seen by the core.
    typedef struct packed {
        logic             mode;
        logic [COL_W-1:0] w_last;
        logic [ROW_W-1:0] h_last;
        logic             restart;
    } cfg_t;

    // One result.
    typedef struct packed {
        logic             pixel_out;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             frame_last;
    } res_t;

    // Last column index of a row, with the width clamped to its legal range.
    function automatic logic [COL_W-1:0] width_last(input logic [FWIDTH_W-1:0] v);
        logic [FWIDTH_W-1:0] t;
        if (v < FWIDTH_W'(3))
            t = FWIDTH_W'(3);
        else if (v > FWIDTH_W'(MAX_WIDTH))
            t = FWIDTH_W'(MAX_WIDTH);
        else
            t = v;
        t = t - FWIDTH_W'(1);
        return t[COL_W-1:0];
    endfunction

    // Last row index of a frame, with the height clamped to its legal range.
    function automatic logic [ROW_W-1:0] height_last(input logic [FHEIGHT_W-1:0] v);
        logic [FHEIGHT_W-1:0] t;
        if (v < FHEIGHT_W'(3))
            t = FHEIGHT_W'(3);
        else if (v > FHEIGHT_W'(MAX_HEIGHT))
            t = FHEIGHT_W'(MAX_HEIGHT);
        else
            t = v;
        t = t - FHEIGHT_W'(1);
        return t[ROW_W-1:0];
    endfunction

endpackage

// File: design/bm3_pix_if.sv
// Input pixel channel: valid/ready handshake carrying one binary pixel.
// Depends on nothing.
interface bm3_pix_if;

    logic valid;
    logic ready;
    logic pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink (input valid, input pixel_in, output ready);

endinterface

// File: design/bm3_res_if.sv
// Result channel: valid/ready handshake carrying a pixel and its coordinates.
// Depends on bm3_pkg for the coordinate widths.
interface bm3_res_if;

    logic                       valid;
    logic                       ready;
    logic                       pixel_out;
    logic [bm3_pkg::ROW_W-1:0]  out_row;
    logic [bm3_pkg::COL_W-1:0]  out_col;
    logic                       frame_last;

    modport source (output valid, output pixel_out, output out_row, output out_col,
                    output frame_last, input ready);
    modport sink (input valid, input pixel_out, input out_row, input out_col,
                  input frame_last, output ready);

endinterface

// File: design/bm3_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module bm3_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/bm3_cfg.sv
// APB register block: mode, frame width and frame height.
// Depends on bm3_pkg for the register widths and the cfg_t bundle.
module bm3_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bm3_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bm3_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bm3_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output bm3_pkg::cfg_t                      cfg
);
    import bm3_pkg::*;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    logic                 mode_reg;
    logic [FWIDTH_W-1:0]  width_reg;
    logic [FHEIGHT_W-1:0] height_reg;
    logic [COL_W-1:0]     w_last_reg;
    logic [ROW_W-1:0]     h_last_reg;
    logic                 wr_en;
    logic [1:0]           reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes; the clamped last indices are kept alongside the raw sizes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            width_reg  <= FWIDTH_W'(128);
            height_reg <= FHEIGHT_W'(192);
            w_last_reg <= COL_W'(127);
            h_last_reg <= ROW_W'(191);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MODE:
                begin
                    mode_reg <= pwdata[0];
                end
                REG_WIDTH:
                begin
                    width_reg  <= pwdata[FWIDTH_W-1:0];
                    w_last_reg <= width_last(pwdata[FWIDTH_W-1:0]);
                end
                REG_HEIGHT:
                begin
                    height_reg <= pwdata[FHEIGHT_W-1:0];
                    h_last_reg <= height_last(pwdata[FHEIGHT_W-1:0]);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Read-back decoder.
    always_comb
    begin
        unique case (reg_idx)
            REG_MODE:   prdata = APB_DATA_W'(mode_reg);
            REG_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // A size write restarts the frame in the core.
    always_comb
    begin
        cfg.mode    = mode_reg;
        cfg.w_last  = w_last_reg;
        cfg.h_last  = h_last_reg;
        cfg.restart = wr_en && ((reg_idx == REG_WIDTH) || (reg_idx == REG_HEIGHT));
    end

endmodule

// File: design/binary_morphology_3x3_core.sv
// Streaming 3x3 binary erosion/dilation with border pass-through.
// Each request is registered in stage 1, and its results in stage 2, which drives the output.
// Throughput: one pixel per cycle while each result is taken; the result port drains one
// result per cycle, so a right-border pixel below the first row and a last-row pixel past
// the first column each give two results, the last pixel of a frame three, and the input waits.
// Reset clears the frame position, the window and the result buffer; line stores
// hold no reset value and are only read where the frame has written them.
module binary_morphology_3x3_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bm3_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bm3_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bm3_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    bm3_pix_if.sink                            pix_in,
    bm3_res_if.source                          res_out
);
    import bm3_pkg::*;

    cfg_t              cfg;

    // Frame position of the next request.
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;

    // Stage 1: pixel waiting for its line store read.
    logic              s1_valid_reg;
    logic              s1_pix_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [5:0]        window_reg;

    // Stage 2: up to three results, drained lowest slot first.
    logic [2:0]        s2_mask_reg;
    res_t              s2_res_reg [3];

    logic              in_fire;
    logic              out_fire;
    logic              s1_adv;
    logic              s2_free;
    logic [LINE_W-1:0] line_rdata;
    logic              above;
    logic              above2;
    logic [2:0]        cur;
    logic [8:0]        nine;
    logic              interior;
    logic              v;
    logic              col_last;
    logic              row_last;
    res_t              res0;
    res_t              res1;
    res_t              res2;
    logic [2:0]        mask_new;
    res_t              out_sel;

    bm3_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake and stage advance.
    assign out_fire     = res_out.valid && res_out.ready;
    assign s2_free      = (s2_mask_reg == 3'b000) || (out_fire && $onehot(s2_mask_reg));
    assign s1_adv       = s1_valid_reg && s2_free;
    assign pix_in.ready = !s1_valid_reg || s1_adv;
    assign in_fire      = pix_in.valid && pix_in.ready;

    // Both line stores share one RAM: bit 0 is row r-1, bit 1 is row r-2.
    // The read is issued at the request; the write-back lands one column later.
    bm3_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata ({above, s1_pix_reg}),
        .re    (in_fire),
        .raddr (col_reg),
        .rdata (line_rdata)
    );

    // Window evaluation and result scheduling for the pixel in stage 1.
    always_comb
    begin
        above    = line_rdata[0];
        above2   = line_rdata[1];
        cur      = {s1_pix_reg, above, above2};
        nine     = {window_reg, cur};
        interior = (s1_row_reg >= ROW_W'(2)) && (s1_col_reg >= COL_W'(2));
        if (interior)
            v = cfg.mode ? (|nine) : (&nine);
        else
            v = window_reg[1];
        col_last = (s1_col_reg == cfg.w_last);
        row_last = (s1_row_reg == cfg.h_last);

        res0.pixel_out  = v;
        res0.out_row    = s1_row_reg - ROW_W'(1);
        res0.out_col    = s1_col_reg - COL_W'(1);
        res0.frame_last = 1'b0;

        res1.pixel_out  = above;
        res1.out_row    = s1_row_reg - ROW_W'(1);
        res1.out_col    = s1_col_reg;
        res1.frame_last = 1'b0;

        res2.pixel_out  = s1_pix_reg;
        res2.out_row    = s1_row_reg;
        res2.out_col    = s1_col_reg;
        res2.frame_last = col_last;

        mask_new[0] = (s1_row_reg != '0) && (s1_col_reg != '0);
        mask_new[1] = (s1_row_reg != '0) && col_last;
        mask_new[2] = row_last;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
            window_reg   <= '0;
            s2_mask_reg  <= '0;
        end
        else
        begin
            // Frame position advances with each request.
            if (cfg.restart)
            begin
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (in_fire)
            begin
                if (col_reg == cfg.w_last)
                begin
                    col_reg <= '0;
                    row_reg <= (row_reg == cfg.h_last) ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end

            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            // The window shifts in the newest column as the pixel leaves stage 1.
            if (cfg.restart)
                window_reg <= '0;
            else if (s1_adv)
                window_reg <= {window_reg[2:0], cur};

            // Result buffer: load on advance, else retire the lowest pending slot.
            if (s1_adv)
                s2_mask_reg <= mask_new;
            else if (out_fire)
                s2_mask_reg <= s2_mask_reg & (s2_mask_reg - 3'd1);
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg <= pix_in.pixel_in;
            s1_row_reg <= row_reg;
            s1_col_reg <= col_reg;
        end
        if (s1_adv)
        begin
            s2_res_reg[0] <= res0;
            s2_res_reg[1] <= res1;
            s2_res_reg[2] <= res2;
        end
    end

    // Present the lowest pending result.
    always_comb
    begin
        if (s2_mask_reg[0])
            out_sel = s2_res_reg[0];
        else if (s2_mask_reg[1])
            out_sel = s2_res_reg[1];
        else
            out_sel = s2_res_reg[2];
    end

    assign res_out.valid      = |s2_mask_reg;
    assign res_out.pixel_out  = out_sel.pixel_out;
    assign res_out.out_row    = out_sel.out_row;
    assign res_out.out_col    = out_sel.out_col;
    assign res_out.frame_last = out_sel.frame_last;

endmodule
